// ===== rtl/u8k2h_pkg.sv =====
// Shared constants and types of the UTF-8 katakana-to-hiragana converter.
// No dependencies; the step, queue, top level and checker files import it.
`default_nettype none

package u8k2h_pkg;

  // code point range of the converted katakana and the offset to hiragana
  localparam logic [15:0] KANA_FIRST = 16'h30A1;
  localparam logic [15:0] KANA_LAST  = 16'h30F6;
  localparam logic [15:0] KANA_SHIFT = 16'h0060;

  // UTF-8 marks of a three-byte sequence
  localparam logic [3:0] LEAD3_TAG  = 4'hE;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  // most result bytes one step can produce
  localparam int unsigned STEP_MAX = 3;

  // default depth of the result queue
  localparam int unsigned OUT_DEPTH = 8;

  // upper bound on bytes held inside: input register, window, result queue
  localparam int unsigned PEND_MAX = 1 + 2 + OUT_DEPTH;

  // results of one step, handed from the step logic to the result queue
  typedef struct packed {
    logic [1:0]      cnt;    // number of result bytes, 0 to 3
    logic [2:0][7:0] bytes;  // result bytes, entry 0 goes out first
    logic            last;   // the final result byte ends the text
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/u8k2h_if.sv =====
// Valid/ready channel interfaces of the converter: byte input and byte output.
// No dependencies.
`default_nettype none

interface u8k2h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8k2h_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8k2h_step.sv =====
// One conversion step: places a byte into the three-byte window, converts katakana
// to hiragana and flushes on end of text. Combinational; uses u8k2h_pkg.
`default_nettype none

module u8k2h_step (
  input  logic [7:0]           win0_i,
  input  logic [7:0]           win1_i,
  input  logic [1:0]           fill_i,
  input  logic [7:0]           byte_i,
  input  logic                 eot_i,
  output u8k2h_pkg::step_res_t res_o,
  output logic [7:0]           win0_o,
  output logic [7:0]           win1_o,
  output logic [1:0]           fill_o
);
  import u8k2h_pkg::*;

  logic [7:0]  w0, w1, w2;
  logic [1:0]  nfill;
  logic        full;
  logic [15:0] cp;
  logic [15:0] hira;
  logic        conv;

  // window after the new byte goes in at the fill position
  assign w0    = (fill_i == 2'd0) ? byte_i : win0_i;
  assign w1    = (fill_i == 2'd1) ? byte_i : win1_i;
  assign w2    = byte_i;
  assign nfill = fill_i + 2'd1;
  assign full  = (fill_i == 2'd2);

  // decode without checking continuation bytes
  assign cp   = {w0[3:0], w1[5:0], w2[5:0]};
  assign conv = full && (w0[7:4] == LEAD3_TAG) && (cp >= KANA_FIRST) && (cp <= KANA_LAST);
  assign hira = cp - KANA_SHIFT;

  // result bytes: re-encoded hiragana, else the window bytes in order
  always_comb begin
    res_o.last = eot_i;
    if (conv) begin
      res_o.bytes[0] = LEAD3_MARK | {4'h0, hira[15:12]};
      res_o.bytes[1] = CONT_MARK | {2'b00, hira[11:6]};
      res_o.bytes[2] = CONT_MARK | {2'b00, hira[5:0]};
      res_o.cnt      = 2'd3;
    end else begin
      res_o.bytes[0] = w0;
      res_o.bytes[1] = w1;
      res_o.bytes[2] = w2;
      if (eot_i) begin
        res_o.cnt = nfill;
      end else if (full) begin
        res_o.cnt = 2'd1;
      end else begin
        res_o.cnt = 2'd0;
      end
    end
  end

  // window left behind for the next byte
  always_comb begin
    if (conv || eot_i) begin
      win0_o = w0;
      win1_o = w1;
      fill_o = 2'd0;
    end else if (full) begin
      win0_o = w1;
      win1_o = w2;
      fill_o = 2'd2;
    end else begin
      win0_o = w0;
      win1_o = w1;
      fill_o = nfill;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8k2h_outq.sv =====
// Result queue: takes up to three bytes per cycle, sends one per cycle while
// the receiver is ready. Register storage with one read position; uses u8k2h_pkg.
`default_nettype none

module u8k2h_outq #(
  parameter int unsigned DEPTH = u8k2h_pkg::OUT_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u8k2h_pkg::step_res_t res_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [7:0]           byte_o,
  output logic                 last_o
);
  import u8k2h_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } entry_t;

  entry_t        mem_q [DEPTH];
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    add_n;
  logic          pop;

  // pointer advance with wrap at the queue depth
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + (PW + 1)'(k);
    if (s >= (PW + 1)'(DEPTH)) begin
      s = s - (PW + 1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign pop     = valid_o && ready_i;
  assign add_n   = push_i ? res_i.cnt : 2'd0;
  assign valid_o = (count_q != '0);
  assign byte_o  = mem_q[rd_ptr_q].data;
  assign last_o  = mem_q[rd_ptr_q].last;
  assign room_o  = (count_q <= CW'(DEPTH - STEP_MAX));

  assign rd_ptr_d = pop ? wrap_add(rd_ptr_q, 2'd1) : rd_ptr_q;
  assign wr_ptr_d = wrap_add(wr_ptr_q, add_n);
  assign count_d  = count_q + CW'(add_n) - CW'(pop);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // write the step results in order, marking the final byte of a text
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STEP_MAX; i++) begin
      if (push_i && (2'(i) < res_i.cnt)) begin
        mem_q[wrap_add(wr_ptr_q, 2'(i))] <= '{
          data: res_i.bytes[i],
          last: res_i.last && (2'(i) == res_i.cnt - 2'd1)
        };
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_katakana_to_hiragana.sv =====
// Top level of the streaming UTF-8 katakana-to-hiragana converter.
// Uses u8k2h_pkg, u8k2h_in_if, u8k2h_out_if, u8k2h_step and u8k2h_outq.
//
// Usage:
//   in_i carries one byte of UTF-8 text per transfer, with end_of_text on the
//   final byte. out_o carries the converted text one byte per transfer, with
//   out_last on the final byte of each text. Katakana U+30A1..U+30F6 leave as
//   the matching hiragana; every other byte passes unchanged. A text gives as
//   many output bytes as input bytes.
//   Order: a byte is held in the input register; once the queue has room, the
//   step that completes its window (or its end of text) writes its results
//   into the result queue, which offers them on out_o.
//   Throughput: one byte per cycle in and out while the queue has room and the
//   receiver is ready. A step may add up to three bytes to the result queue
//   (OUT_DEPTH entries); the input register moves on only while the queue has
//   room for three, so in steady flow the queue never throttles the input.
//   Reset empties the window, the input register and the result queue.
//   When the receiver stalls, out_o holds its byte, the queue fills and in_i
//   ready drops once the queue lacks room for a full step.
`default_nettype none

module utf8_katakana_to_hiragana #(
  parameter int unsigned OUT_DEPTH = u8k2h_pkg::OUT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8k2h_in_if.sink    in_i,
  u8k2h_out_if.source out_o
);
  import u8k2h_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic [7:0] win0_q, win0_d;
  logic [7:0] win1_q, win1_d;
  logic [1:0] fill_q, fill_d;
  step_res_t  res;
  logic       room;
  logic       adv;
  logic       in_xfer;

  // the input register hands on its byte when the queue can take a full step
  assign adv      = in_vld_q && room;
  assign in_i.ready = !in_vld_q || adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_i.in_byte;
      in_eot_q  <= in_i.end_of_text;
    end
  end

  // window conversion logic
  u8k2h_step u_step (
    .win0_i (win0_q),
    .win1_i (win1_q),
    .fill_i (fill_q),
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .res_o  (res),
    .win0_o (win0_d),
    .win1_o (win1_d),
    .fill_o (fill_d)
  );

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else if (adv) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      win0_q <= win0_d;
      win1_q <= win1_d;
    end
  end

  // result queue drives the output channel
  u8k2h_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv),
    .res_i   (res),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .byte_o  (out_o.out_byte),
    .last_o  (out_o.out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/u8k2h_chk.sv =====
// Port-level checker of the converter, bound to the top level.
// Uses u8k2h_pkg; attaches to utf8_katakana_to_hiragana.
`default_nettype none

module u8k2h_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);
  import u8k2h_pkg::*;

  localparam int unsigned PCW = $clog2(PEND_MAX + 2);

  logic           in_xfer;
  logic           out_xfer;
  logic [PCW-1:0] pend_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // bytes taken in and not yet sent out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PCW'(in_xfer) - PCW'(out_xfer);
    end
  end

  // a stalled output keeps its transfer offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // a stalled output keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i))
    else $error("output payload changed while stalled");

  // no output byte without an input byte behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (pend_q != '0) || in_xfer)
    else $error("output byte sent with nothing taken in");

  // the block never holds more bytes than its storage allows
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PCW'(PEND_MAX))
    else $error("more bytes held than storage allows");

endmodule

bind utf8_katakana_to_hiragana u8k2h_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);

`default_nettype wire
